FILE: rtl/fpsq_pkg.sv
// Package for the frame/priority sorted event queue.
// Holds the word types, sizing constants, operation and status codes and the sort compare.
// No dependencies.
package fpsq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int Q_AW = $clog2(QUEUE_DEPTH);
  localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PEND_W = 7;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [15:0] event_handle;
    logic [31:0] exec_frame;
    logic [7:0] event_priority;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic entry_valid;
    logic [15:0] out_handle;
    logic [31:0] out_frame;
    logic [7:0] out_priority;
    logic [PEND_W-1:0] pending_count;
  } out_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] frame;
    logic [7:0] prio;
  } entry_t;

  // True when entry a must sit behind entry b: later frame, or same frame and lower priority.
  function automatic logic goes_after(entry_t a, entry_t b);
    goes_after = (a.frame > b.frame) || ((a.frame == b.frame) && (a.prio < b.prio));
  endfunction

endpackage

FILE: rtl/frame_priority_sorted_event_queue_unit.sv
// Top level of the frame/priority sorted event queue: sequencer, entry memory and output register.
// Depends on fpsq_pkg.
//
//   port group   direction   word          handshake
//   in_*         input       fpsq_pkg::in_t  in_valid / in_stall
//   out_*        output      fpsq_pkg::out_t out_valid / out_stall
//
// One word is worked on at a time; the single-port-read entry memory sets the pace.
// Dequeue and peek read the entry at the cursor, then pass the result to the output register;
// a refused enqueue, a read with nothing pending and a clear with nothing dequeued go straight there;
// an enqueue reads and shifts back one entry at a time until it stops on a compare or at the read
// cursor, then writes the new entry; a clear reads each pending entry and writes it further down.
// Reset (rst_n low at a clock edge) empties the queue; memory contents are not cleared.
// A new word is taken while a finished result still waits in the output register;
// its own result waits inside until out_stall drops.
module frame_priority_sorted_event_queue_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fpsq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output fpsq_pkg::out_t out_data
);
  import fpsq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ENQ_CHK = 3'd1;
  localparam logic [2:0] S_ENQ_CMP = 3'd2;
  localparam logic [2:0] S_DQ      = 3'd3;
  localparam logic [2:0] S_CLR_RD  = 3'd4;
  localparam logic [2:0] S_CLR_WR  = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic [Q_CW-1:0] cursor_r, cursor_nxt;
  logic [Q_CW-1:0] pos_r, pos_nxt;
  logic [Q_AW-1:0] dst_r, dst_nxt;
  logic [1:0] op_r, op_nxt;
  entry_t item_r, item_nxt;
  out_t res_r, res_nxt;
  out_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  // Entry memory signals.
  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;
  logic mem_we;
  logic [Q_AW-1:0] mem_waddr;
  entry_t mem_wdata;
  logic mem_re;
  logic [Q_AW-1:0] mem_raddr;

  logic in_acc;
  logic [Q_CW-1:0] pos_m1;
  out_t res_none;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign pos_m1 = pos_r - Q_CW'(1);

  // Result with no entry returned.
  always_comb begin
    res_none = '0;
    res_none.status = ST_OK;
  end

  // Sequencer: next state, pointers and memory accesses.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cursor_nxt = cursor_r;
    pos_nxt = pos_r;
    dst_nxt = dst_r;
    op_nxt = op_r;
    item_nxt = item_r;
    res_nxt = res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    mem_we = 1'b0;
    mem_waddr = pos_r[Q_AW-1:0];
    mem_wdata = item_r;
    mem_re = 1'b0;
    mem_raddr = pos_m1[Q_AW-1:0];

    // The output register empties when its word is taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = in_data.op;
          item_nxt.handle = in_data.event_handle;
          item_nxt.frame = in_data.exec_frame;
          item_nxt.prio = in_data.event_priority;
          res_nxt = res_none;
          case (in_data.op)
            OP_ENQUEUE: begin
              if (count_r == Q_CW'(QUEUE_DEPTH)) begin
                res_nxt.status = ST_FULL;
                state_nxt = S_OUT;
              end else begin
                pos_nxt = count_r;
                state_nxt = S_ENQ_CHK;
              end
            end
            OP_DEQUEUE, OP_PEEK: begin
              if (cursor_r < count_r) begin
                mem_re = 1'b1;
                mem_raddr = cursor_r[Q_AW-1:0];
                state_nxt = S_DQ;
              end else begin
                res_nxt.status = ST_EMPTY;
                state_nxt = S_OUT;
              end
            end
            default: begin
              // Clear: move pending entries down by the cursor distance.
              if (cursor_r == '0) begin
                state_nxt = S_OUT;
              end else begin
                pos_nxt = cursor_r;
                dst_nxt = '0;
                state_nxt = S_CLR_RD;
              end
            end
          endcase
        end
      end

      // Read the neighbor in front, or drop the new entry into place.
      S_ENQ_CHK: begin
        if (pos_r > cursor_r) begin
          mem_re = 1'b1;
          mem_raddr = pos_m1[Q_AW-1:0];
          state_nxt = S_ENQ_CMP;
        end else begin
          mem_we = 1'b1;
          mem_waddr = pos_r[Q_AW-1:0];
          mem_wdata = item_r;
          count_nxt = count_r + Q_CW'(1);
          state_nxt = S_OUT;
        end
      end

      // Shift the neighbor back one place if it sorts after the new entry.
      S_ENQ_CMP: begin
        if (goes_after(rd_q, item_r)) begin
          mem_we = 1'b1;
          mem_waddr = pos_r[Q_AW-1:0];
          mem_wdata = rd_q;
          pos_nxt = pos_m1;
          state_nxt = S_ENQ_CHK;
        end else begin
          mem_we = 1'b1;
          mem_waddr = pos_r[Q_AW-1:0];
          mem_wdata = item_r;
          count_nxt = count_r + Q_CW'(1);
          state_nxt = S_OUT;
        end
      end

      // Entry at the cursor has been read.
      S_DQ: begin
        res_nxt.status = ST_OK;
        res_nxt.entry_valid = 1'b1;
        res_nxt.out_handle = rd_q.handle;
        res_nxt.out_frame = rd_q.frame;
        res_nxt.out_priority = rd_q.prio;
        if (op_r == OP_DEQUEUE) begin
          cursor_nxt = cursor_r + Q_CW'(1);
        end
        state_nxt = S_OUT;
      end

      // Clear: read the next pending entry, or finish.
      S_CLR_RD: begin
        if (pos_r < count_r) begin
          mem_re = 1'b1;
          mem_raddr = pos_r[Q_AW-1:0];
          state_nxt = S_CLR_WR;
        end else begin
          count_nxt = count_r - cursor_r;
          cursor_nxt = '0;
          state_nxt = S_OUT;
        end
      end

      S_CLR_WR: begin
        mem_we = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = rd_q;
        dst_nxt = dst_r + Q_AW'(1);
        pos_nxt = pos_r + Q_CW'(1);
        state_nxt = S_CLR_RD;
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = res_r;
          out_nxt.pending_count = PEND_W'(count_r - cursor_r);
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cursor_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cursor_r <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    dst_r <= dst_nxt;
    op_r <= op_nxt;
    item_r <= item_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTH
  // The cursor never passes the number of stored entries.
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("read cursor beyond stored count");

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(QUEUE_DEPTH))
    else $error("stored count beyond depth");

  // The memory is written only while a word is being worked on.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

  // A returned entry always comes with status ok.
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.entry_valid) |-> (out_r.status == ST_OK))
    else $error("returned entry with non-ok status");
`endif

endmodule
